// ===== src/acls_pkg.sv =====
// Shared types, constants and saturation helpers for the consensus lighting step.
package acls_pkg;

   localparam int NODE_SLOTS = 8;
   localparam int IW        = $clog2(NODE_SLOTS);
   localparam int NW        = IW + 1;
   localparam int AW        = 2 * IW;
   localparam int FRAC_BITS = 16;
   localparam int DW        = 32;
   localparam int QW        = 64;
   localparam int MW        = QW - FRAC_BITS;
   localparam int DUTY_W    = 23;
   localparam int PAW       = 5;

   typedef logic signed [DW-1:0] q_type;
   typedef logic signed [QW-1:0] wide_type;

   localparam wide_type ONE_W       = 64'sd1 <<< FRAC_BITS;
   localparam wide_type ROUND_W     = ONE_W >>> 1;
   localparam wide_type FIVE_W      = ONE_W * 5;
   localparam wide_type FULL_W      = ONE_W * 100;
   localparam wide_type TWO_W       = ONE_W * 2;
   localparam wide_type HALF_ONE_SQ = (ONE_W * ONE_W) >>> 1;
   localparam wide_type THRESH_W    = (ONE_W + 500) / 1000;
   localparam wide_type I32MAX_W    = 64'sd2147483647;
   localparam wide_type I32MIN_W    = -64'sd2147483648;
   // magnitude / 100 as a multiply by ceil(2^38 / 100) and a shift, exact below 2^32
   localparam logic [QW-1:0] GAIN_RECIP = 64'd2748779070;
   localparam int            GAIN_SHIFT = 38;

   localparam logic [1:0] OP_ELEM  = 2'd0;
   localparam logic [1:0] OP_GAIN  = 2'd1;
   localparam logic [1:0] OP_ITER  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [2:0] REG_RHO     = 3'd0;
   localparam logic [2:0] REG_COST    = 3'd1;
   localparam logic [2:0] REG_COUNT   = 3'd2;
   localparam logic [2:0] REG_INDEX   = 3'd3;
   localparam logic [2:0] REG_PRESENT = 3'd4;

   typedef struct packed {
      logic            start;
      logic            floor_mode;
      logic [QW-1:0]   num;
      logic [QW-1:0]   den;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [QW-1:0]   quo;
   } div_rsp_type;

   function automatic q_type sat32(input wide_type v);
      q_type r;
      if (v > I32MAX_W) r = {1'b0, {(DW-1){1'b1}}};
      else if (v < I32MIN_W) r = {1'b1, {(DW-1){1'b0}}};
      else r = v[DW-1:0];
      return r;
   endfunction

   function automatic wide_type sx(input q_type v);
      return wide_type'(v);
   endfunction

endpackage

// ===== src/admm_consensus_lighting_step.sv =====
// Iterate: busy through the node loops, every solver step and the projection on
// a step that projects; paced by the shared registered multiplier and the shared
// restoring divider. Absent node: busy only while the zero duties are emitted.
// Gain write: busy while the gain is stored. Element write and clear: not busy.
// Results are strobed one per cycle, no stall; a new command is taken once busy drops.
// Synchronous reset loads the register defaults and clears all node state.
module admm_consensus_lighting_step import acls_pkg::*; #(
   parameter int SOLVER_STEPS = 50
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [2:0]        req_row_index,
   input  logic [2:0]        req_col_index,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_measured_lux,
   input  logic signed [31:0] req_reference_lux,
   output logic              rsp_valid,
   output logic [2:0]        rsp_node_slot,
   output logic [22:0]       rsp_duty,
   output logic              rsp_is_own,
   output logic              rsp_forced_full,
   output logic              rsp_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [PAW-1:0]    paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   localparam int SW = (SOLVER_STEPS > 1) ? $clog2(SOLVER_STEPS) : 1;

   typedef enum logic [5:0] {
      S_IDLE, S_G_SCALE, S_DP_RD, S_DP_MUL, S_DP_ACC, S_D_FIN, S_WROW,
      S_AV_RD, S_AV_ACC, S_AV_DIV, S_AV_WAIT, S_DU_MUL, S_DU_ACC, S_ST_DIV, S_ST_WAIT,
      S_KN_MUL, S_KN_ACC, S_GR_MUL, S_GR_G, S_GR_M2, S_GR_U, S_ES_MUL, S_ES_ACC,
      S_PJ_CHK, S_PJ_DIV, S_PJ_WAIT, S_PJ_MUL, S_PJ_ACC, S_CL, S_FS_MUL, S_FS_ACC,
      S_FS_CHK, S_EMIT
   } state_type;

   // configuration
   logic [30:0]   rho_ff;
   logic [30:0]   cost_ff;
   logic [3:0]    count_ff;
   logic [2:0]    index_ff;
   logic          present_cfg_ff;
   logic          csr_wr;
   logic [2:0]    csr_idx;

   // sequencer and datapath
   state_type     state_ff;
   logic [IW-1:0] i_ff;
   logic [IW-1:0] j_ff;
   logic [SW-1:0] it_ff;
   logic [NW-1:0] n_ff;
   logic [IW-1:0] nm1_ff;
   logic [IW-1:0] me_ff;
   logic          present_ff;
   logic          forced_ff;
   q_type         val_ff;
   logic [IW-1:0] gcol_ff;
   q_type         meas_ff;
   q_type         ref_ff;
   q_type         target_ff;
   wide_type      acc_ff;
   wide_type      knorm_ff;
   q_type         step_ff;
   q_type         ratio_ff;
   q_type         g_ff;
   q_type         own_ff  [NODE_SLOTS];
   q_type         avg_ff  [NODE_SLOTS];
   q_type         dual_ff [NODE_SLOTS];
   q_type         gain_ff [NODE_SLOTS];
   q_type         u_ff    [NODE_SLOTS];
   q_type         u_clamp [NODE_SLOTS];
   logic [NODE_SLOTS*NODE_SLOTS-1:0] valid_ff;
   logic          rvld_ff;

   logic          rsp_valid_ff;
   logic [2:0]    rsp_slot_ff;
   logic [22:0]   rsp_duty_ff;
   logic          rsp_own_ff;
   logic          rsp_forced_ff;
   logic          rsp_last_ff;

   // memory and shared units
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   q_type         ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [DW-1:0] ram_rdata;
   q_type         ram_val;
   q_type         mul_a;
   q_type         mul_b;
   logic signed [MW-1:0] mul_q;
   wide_type      mq;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   q_type         div_q32;

   logic [NW-1:0] n_now;
   logic          present_now;
   logic [30:0]   rho_eff;
   q_type         r32;
   q_type         c32;
   logic          is_last;
   wide_type      acc_sum;
   q_type         dot32;
   q_type         dist_raw;
   q_type         dist_pos;
   q_type         tgt_calc;
   q_type         diff_own;
   q_type         diff_u;
   q_type         g_calc;
   wide_type      dual_sum;
   q_type         dual_new;
   q_type         est;
   logic          do_proj;
   wide_type      fs_low;
   logic [DW-1:0] gain_mag;
   logic [QW-1:0] gain_prod;
   logic [DW-1:0] gain_abs;
   q_type         gain_quo;

   acls_ram #(.WIDTH(DW), .DEPTH(NODE_SLOTS*NODE_SLOTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   acls_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .q     (mul_q)
   );

   acls_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // configuration port
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[PAW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rho_ff         <= 31'(ONE_W);
         cost_ff        <= 31'(ONE_W);
         count_ff       <= 4'd1;
         index_ff       <= '0;
         present_cfg_ff <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_RHO:     rho_ff         <= pwdata[30:0];
            REG_COST:    cost_ff        <= pwdata[30:0];
            REG_COUNT:   count_ff       <= pwdata[3:0];
            REG_INDEX:   index_ff       <= pwdata[2:0];
            REG_PRESENT: present_cfg_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_RHO:     prdata = {1'b0, rho_ff};
         REG_COST:    prdata = {1'b0, cost_ff};
         REG_COUNT:   prdata = {28'd0, count_ff};
         REG_INDEX:   prdata = {29'd0, index_ff};
         REG_PRESENT: prdata = {31'd0, present_cfg_ff};
         default:     prdata = '0;
      endcase
   end

   // operand preparation
   always_comb begin
      if (count_ff == '0) n_now = NW'(1);
      else if (count_ff > 4'(NODE_SLOTS)) n_now = NW'(NODE_SLOTS);
      else n_now = NW'(count_ff);
   end

   assign present_now = present_cfg_ff && (NW'(index_ff) < n_now);
   assign rho_eff  = (rho_ff == '0) ? 31'd1 : rho_ff;
   assign r32      = {1'b0, rho_eff};
   assign c32      = sat32(((wide_type'(cost_ff) <<< 1) + wide_type'(cost_ff) + 64'sd1) >>> 1);
   assign is_last  = (i_ff == nm1_ff);
   assign ram_val  = rvld_ff ? ram_rdata : '0;
   assign mq       = wide_type'(mul_q);
   assign acc_sum  = acc_ff + mq;
   assign div_q32  = sat32(div_rsp.quo);

   // gain / 100, truncated toward zero, on the magnitude
   assign gain_mag  = val_ff[DW-1] ? (~val_ff + 1'b1) : val_ff;
   assign gain_prod = QW'(gain_mag) * GAIN_RECIP;
   assign gain_abs  = DW'(gain_prod >> GAIN_SHIFT);
   assign gain_quo  = val_ff[DW-1] ? q_type'(~gain_abs + 1'b1) : q_type'(gain_abs);

   assign dot32    = sat32(acc_ff);
   assign dist_raw = sat32(sx(meas_ff) - sx(dot32));
   assign dist_pos = dist_raw[DW-1] ? '0 : dist_raw;
   assign tgt_calc = sat32(sx(ref_ff) - sx(dist_pos));

   assign diff_own = sat32(sx(own_ff[i_ff]) - sx(avg_ff[i_ff]));
   assign diff_u   = sat32(sx(u_ff[i_ff]) - sx(avg_ff[i_ff]));
   assign g_calc   = sat32(sx(c32) + sx(dual_ff[i_ff]) + sx(sat32(mq)));
   assign dual_sum = sx(dual_ff[i_ff]) + mq;

   always_comb begin
      if (dual_sum > FIVE_W) dual_new = FIVE_W[DW-1:0];
      else if (dual_sum < -FIVE_W) dual_new = DW'(-FIVE_W);
      else dual_new = dual_sum[DW-1:0];
   end

   assign est     = sat32(acc_ff);
   assign do_proj = (sx(est) < sx(target_ff)) && (knorm_ff > THRESH_W);
   assign fs_low  = sx(target_ff) - TWO_W;

   always_comb begin
      for (int k = 0; k < NODE_SLOTS; k++) begin
         if (u_ff[k] < 0) u_clamp[k] = '0;
         else if (sx(u_ff[k]) > FULL_W) u_clamp[k] = FULL_W[DW-1:0];
         else u_clamp[k] = u_ff[k];
      end
   end

   // memory access
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {req_row_index, req_col_index};
      ram_wdata = req_value;
      if (state_ff == S_IDLE && start && req_opcode == OP_ELEM) begin
         ram_we = 1'b1;
      end else if (state_ff == S_WROW) begin
         ram_we    = 1'b1;
         ram_waddr = {me_ff, i_ff};
         ram_wdata = own_ff[i_ff];
      end
   end

   always_comb begin
      unique case (state_ff)
         S_DP_RD: ram_raddr = {i_ff, i_ff};
         S_AV_RD: ram_raddr = {i_ff, j_ff};
         default: ram_raddr = '0;
      endcase
   end

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         S_DP_MUL: begin
            mul_a = gain_ff[i_ff];
            mul_b = (i_ff == me_ff) ? own_ff[i_ff] : ram_val;
         end
         S_DU_MUL: begin
            mul_a = r32;
            mul_b = diff_own;
         end
         S_KN_MUL: begin
            mul_a = gain_ff[i_ff];
            mul_b = gain_ff[i_ff];
         end
         S_GR_MUL: begin
            mul_a = r32;
            mul_b = diff_u;
         end
         S_GR_M2: begin
            mul_a = step_ff;
            mul_b = g_ff;
         end
         S_ES_MUL, S_FS_MUL: begin
            mul_a = u_ff[i_ff];
            mul_b = gain_ff[i_ff];
         end
         S_PJ_MUL: begin
            mul_a = gain_ff[i_ff];
            mul_b = ratio_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // shared divider requests
   always_comb begin
      div_req = '0;
      unique case (state_ff)
         S_AV_DIV: begin
            div_req.start      = 1'b1;
            div_req.floor_mode = 1'b1;
            div_req.num        = (acc_ff <<< 1) + wide_type'(n_ff);
            div_req.den        = QW'(n_ff) << 1;
         end
         S_ST_DIV: begin
            div_req.start      = 1'b1;
            div_req.floor_mode = 1'b1;
            div_req.num        = HALF_ONE_SQ + wide_type'(rho_eff >> 1);
            div_req.den        = QW'(rho_eff);
         end
         S_PJ_DIV: begin
            div_req.start      = 1'b1;
            div_req.floor_mode = 1'b1;
            div_req.num        = ((sx(target_ff) - sx(est)) <<< FRAC_BITS) + (knorm_ff >>> 1);
            div_req.den        = knorm_ff;
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         it_ff        <= '0;
         forced_ff    <= 1'b0;
         rvld_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NODE_SLOTS; k++) begin
            own_ff[k]  <= '0;
            avg_ff[k]  <= '0;
            dual_ff[k] <= '0;
            gain_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         rvld_ff      <= valid_ff[ram_raddr];
         if (ram_we) valid_ff[ram_waddr] <= 1'b1;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  unique case (req_opcode)
                     OP_ELEM: ;
                     OP_GAIN: begin
                        val_ff   <= req_value;
                        gcol_ff  <= req_col_index;
                        state_ff <= S_G_SCALE;
                     end
                     OP_ITER: begin
                        n_ff       <= n_now;
                        nm1_ff     <= IW'(n_now - 1'b1);
                        me_ff      <= index_ff;
                        present_ff <= present_now;
                        meas_ff    <= req_measured_lux;
                        ref_ff     <= req_reference_lux;
                        forced_ff  <= 1'b0;
                        i_ff       <= '0;
                        acc_ff     <= '0;
                        state_ff   <= present_now ? S_DP_RD : S_EMIT;
                     end
                     OP_CLEAR: begin
                        valid_ff <= '0;
                        for (int k = 0; k < NODE_SLOTS; k++) begin
                           own_ff[k]  <= '0;
                           avg_ff[k]  <= '0;
                           dual_ff[k] <= '0;
                           gain_ff[k] <= '0;
                        end
                     end
                  endcase
               end
            end
            S_G_SCALE: begin
               gain_ff[gcol_ff] <= gain_quo;
               state_ff         <= S_IDLE;
            end
            S_DP_RD: state_ff <= S_DP_MUL;
            S_DP_MUL: state_ff <= S_DP_ACC;
            S_DP_ACC: begin
               acc_ff <= acc_sum;
               if (is_last) state_ff <= S_D_FIN;
               else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_DP_RD;
               end
            end
            S_D_FIN: begin
               target_ff <= tgt_calc;
               i_ff      <= '0;
               state_ff  <= S_WROW;
            end
            S_WROW: begin
               if (is_last) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_AV_RD;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_AV_RD: state_ff <= S_AV_ACC;
            S_AV_ACC: begin
               acc_ff <= acc_ff + sx(ram_val);
               if (is_last) state_ff <= S_AV_DIV;
               else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_AV_RD;
               end
            end
            S_AV_DIV: state_ff <= S_AV_WAIT;
            S_AV_WAIT: begin
               if (div_rsp.done) begin
                  avg_ff[j_ff] <= div_q32;
                  acc_ff       <= '0;
                  i_ff         <= '0;
                  if (j_ff == nm1_ff) state_ff <= S_DU_MUL;
                  else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= S_AV_RD;
                  end
               end
            end
            S_DU_MUL: state_ff <= S_DU_ACC;
            S_DU_ACC: begin
               dual_ff[i_ff] <= dual_new;
               if (is_last) begin
                  i_ff     <= '0;
                  state_ff <= S_ST_DIV;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_DU_MUL;
               end
            end
            S_ST_DIV: begin
               // solver starts from the consensus average
               for (int k = 0; k < NODE_SLOTS; k++) u_ff[k] <= avg_ff[k];
               state_ff <= S_ST_WAIT;
            end
            S_ST_WAIT: begin
               if (div_rsp.done) begin
                  step_ff  <= div_q32;
                  acc_ff   <= '0;
                  i_ff     <= '0;
                  state_ff <= S_KN_MUL;
               end
            end
            S_KN_MUL: state_ff <= S_KN_ACC;
            S_KN_ACC: begin
               acc_ff <= acc_sum;
               if (is_last) begin
                  knorm_ff <= acc_sum;
                  i_ff     <= '0;
                  it_ff    <= '0;
                  state_ff <= S_GR_MUL;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_KN_MUL;
               end
            end
            S_GR_MUL: state_ff <= S_GR_G;
            S_GR_G: begin
               g_ff     <= g_calc;
               state_ff <= S_GR_M2;
            end
            S_GR_M2: state_ff <= S_GR_U;
            S_GR_U: begin
               u_ff[i_ff] <= sat32(sx(u_ff[i_ff]) - mq);
               if (is_last) begin
                  i_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_ES_MUL;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_GR_MUL;
               end
            end
            S_ES_MUL: state_ff <= S_ES_ACC;
            S_ES_ACC: begin
               acc_ff <= acc_sum;
               if (is_last) begin
                  i_ff     <= '0;
                  state_ff <= S_PJ_CHK;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_ES_MUL;
               end
            end
            S_PJ_CHK: state_ff <= do_proj ? S_PJ_DIV : S_CL;
            S_PJ_DIV: state_ff <= S_PJ_WAIT;
            S_PJ_WAIT: begin
               if (div_rsp.done) begin
                  ratio_ff <= div_q32;
                  i_ff     <= '0;
                  state_ff <= S_PJ_MUL;
               end
            end
            S_PJ_MUL: state_ff <= S_PJ_ACC;
            S_PJ_ACC: begin
               u_ff[i_ff] <= sat32(sx(u_ff[i_ff]) + mq);
               if (is_last) begin
                  i_ff     <= '0;
                  state_ff <= S_CL;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_PJ_MUL;
               end
            end
            S_CL: begin
               for (int k = 0; k < NODE_SLOTS; k++) u_ff[k] <= u_clamp[k];
               i_ff <= '0;
               if (it_ff == SW'(SOLVER_STEPS - 1)) begin
                  for (int k = 0; k < NODE_SLOTS; k++) begin
                     if (k < int'(n_ff)) own_ff[k] <= u_clamp[k];
                  end
                  acc_ff   <= '0;
                  state_ff <= S_FS_MUL;
               end else begin
                  it_ff    <= it_ff + 1'b1;
                  state_ff <= S_GR_MUL;
               end
            end
            S_FS_MUL: state_ff <= S_FS_ACC;
            S_FS_ACC: begin
               acc_ff <= acc_sum;
               if (is_last) state_ff <= S_FS_CHK;
               else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_FS_MUL;
               end
            end
            S_FS_CHK: begin
               // too dark even after solving: drive every light full on
               if (acc_ff < fs_low) begin
                  for (int k = 0; k < NODE_SLOTS; k++) begin
                     if (k < int'(n_ff)) own_ff[k] <= FULL_W[DW-1:0];
                  end
                  forced_ff <= 1'b1;
               end
               i_ff     <= '0;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               rsp_valid_ff  <= 1'b1;
               rsp_slot_ff   <= i_ff;
               rsp_duty_ff   <= present_ff ? own_ff[i_ff][DUTY_W-1:0] : '0;
               rsp_own_ff    <= (i_ff == me_ff);
               rsp_forced_ff <= forced_ff;
               rsp_last_ff   <= is_last;
               if (is_last) state_ff <= S_IDLE;
               else i_ff <= i_ff + 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_slot   = rsp_slot_ff;
   assign rsp_duty        = rsp_duty_ff;
   assign rsp_is_own      = rsp_own_ff;
   assign rsp_forced_full = rsp_forced_ff;
   assign rsp_last        = rsp_last_ff;
endmodule

// ===== src/acls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/acls_mul.sv =====
// Shared signed fixed-point multiplier, rounded half up, registered result.
module acls_mul import acls_pkg::*; (
   input  logic                 clock,
   input  q_type                a,
   input  q_type                b,
   output logic signed [MW-1:0] q
);
   wide_type prod;
   wide_type prod_rnd;
   logic signed [MW-1:0] q_ff;

   assign prod     = wide_type'(a) * wide_type'(b);
   assign prod_rnd = prod + ROUND_W;

   always_ff @(posedge clock) begin
      q_ff <= prod_rnd[QW-1:FRAC_BITS];
   end

   assign q = q_ff;
endmodule

// ===== src/acls_div.sv =====
// Shared restoring divider, one quotient bit per cycle, floor or truncating.
module acls_div import acls_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   localparam int CW = $clog2(QW);

   logic          run_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [QW-1:0] quo_ff;
   logic [QW-1:0] rem_ff;
   logic [QW-1:0] den_ff;
   logic          neg_ff;
   logic          floor_ff;
   logic [QW:0]   trial;
   logic [QW:0]   diff;
   logic [QW-1:0] mag;
   logic [QW-1:0] adj;

   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign mag   = req.num[QW-1] ? (~req.num + 1'b1) : req.num;
   assign adj   = quo_ff + QW'(neg_ff & floor_ff & (rem_ff != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff   <= 1'b1;
            cnt_ff   <= '0;
            quo_ff   <= mag;
            rem_ff   <= '0;
            den_ff   <= req.den;
            neg_ff   <= req.num[QW-1];
            floor_ff <= req.floor_mode;
         end else if (run_ff) begin
            if (!diff[QW]) begin
               rem_ff <= diff[QW-1:0];
               quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= trial[QW-1:0];
               quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(QW-1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = neg_ff ? (~adj + 1'b1) : quo_ff;
endmodule

// ===== src/acls_chk.sv =====
// Port-level checks for the consensus lighting step, bound to the top level.
module acls_chk import acls_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_node_slot,
   input logic [22:0] rsp_duty,
   input logic        rsp_forced_full,
   input logic        rsp_last
);
   a_busy_from_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted transfer");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result strobe directly after the last entry");

   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_node_slot == 3'($past(rsp_node_slot) + 1'b1))
      else $error("result vector not contiguous");

   a_forced_full_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forced_full |-> rsp_duty == 23'(FULL_W))
      else $error("failsafe result without full duty");
endmodule

bind admm_consensus_lighting_step acls_chk u_chk (.*);

// ===== sim/admm_consensus_lighting_step_checker.sv =====
// Checker for the consensus lighting step: tracks registers, predicts duty vectors, compares.
module admm_consensus_lighting_step_checker import acls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [2:0]        req_row_index,
   input  logic [2:0]        req_col_index,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_measured_lux,
   input  logic signed [31:0] req_reference_lux,
   input  logic              rsp_valid,
   input  logic [2:0]        rsp_node_slot,
   input  logic [22:0]       rsp_duty,
   input  logic              rsp_is_own,
   input  logic              rsp_forced_full,
   input  logic              rsp_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [PAW-1:0]    paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                errors,
   output int                pending,
   output int                results_seen,
   output int                failsafe_seen
);

   localparam longint UNIT = 64'sd65536;

   typedef struct packed {
      logic [2:0]  slot;
      logic [22:0] duty;
      logic        own;
      logic        forced;
      logic        last;
   } duty_entry_type;

   duty_entry_type duty_expected[$];

   longint rho_q, cost_q;
   int     count_cfg, index_cfg;
   bit     present_cfg;
   int     own_duty[8], avg_duty[8], dual_duty[8], gain_q[8], net_duty[64];
   int     err_count, seen_count, fail_count;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor_div(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return floor_div(a * b + UNIT / 2, UNIT);
   endfunction

   function automatic void wipe_node_state();
      for (int i = 0; i < 8; i++) begin
         own_duty[i] = 0;
         avg_duty[i] = 0;
         dual_duty[i] = 0;
         gain_q[i] = 0;
      end
      for (int i = 0; i < 64; i++) net_duty[i] = 0;
   endfunction

   // Run one consensus solve; returns 1 when the failsafe forces full duty.
   function automatic bit solve_duties(input int n, input int me, input longint meas,
                                       input longint lux_ref);
      longint phys[8], u[8];
      longint r, c, d, target, step, thr, knorm, acc, v, diff, g, est, corr, ratio;
      r = (rho_q != 0) ? rho_q : 1;
      c = clamp32(floor_div(3 * cost_q + 1, 2));
      for (int i = 0; i < n; i++) phys[i] = (i == me) ? own_duty[i] : net_duty[i*8+i];
      acc = 0;
      for (int i = 0; i < n; i++) acc += qmul(gain_q[i], phys[i]);
      d = clamp32(meas - clamp32(acc));
      if (d < 0) d = 0;
      target = clamp32(lux_ref - d);
      for (int i = 0; i < n; i++) net_duty[me*8+i] = own_duty[i];
      for (int j = 0; j < n; j++) begin
         acc = 0;
         for (int i = 0; i < n; i++) acc += net_duty[i*8+j];
         avg_duty[j] = int'(clamp32(floor_div(2 * acc + n, 2 * longint'(n))));
      end
      for (int i = 0; i < n; i++) begin
         diff = clamp32(longint'(own_duty[i]) - avg_duty[i]);
         v = longint'(dual_duty[i]) + qmul(r, diff);
         if (v > 5 * UNIT) v = 5 * UNIT;
         if (v < -5 * UNIT) v = -5 * UNIT;
         dual_duty[i] = int'(v);
      end
      for (int i = 0; i < n; i++) u[i] = avg_duty[i];
      step = clamp32(floor_div(UNIT * UNIT / 2 + r / 2, r));
      thr = floor_div(UNIT + 500, 1000);
      knorm = 0;
      for (int i = 0; i < n; i++) knorm += qmul(gain_q[i], gain_q[i]);
      for (int it = 0; it < 50; it++) begin
         for (int i = 0; i < n; i++) begin
            diff = clamp32(u[i] - avg_duty[i]);
            g = clamp32(c + dual_duty[i] + clamp32(qmul(r, diff)));
            u[i] = clamp32(u[i] - qmul(step, g));
         end
         acc = 0;
         for (int i = 0; i < n; i++) acc += qmul(u[i], gain_q[i]);
         est = clamp32(acc);
         if (est < target && knorm > thr) begin
            corr = target - est;
            ratio = clamp32(floor_div(corr * UNIT + knorm / 2, knorm));
            for (int i = 0; i < n; i++) u[i] = clamp32(u[i] + qmul(gain_q[i], ratio));
         end
         for (int i = 0; i < n; i++) begin
            if (u[i] < 0) u[i] = 0;
            if (u[i] > 100 * UNIT) u[i] = 100 * UNIT;
         end
      end
      for (int i = 0; i < n; i++) own_duty[i] = int'(u[i]);
      acc = 0;
      for (int i = 0; i < n; i++) acc += qmul(own_duty[i], gain_q[i]);
      if (acc < target - 2 * UNIT) begin
         for (int i = 0; i < n; i++) own_duty[i] = int'(100 * UNIT);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      duty_entry_type got, want;
      int n;
      bit here, forced;
      if (reset) begin
         rho_q = UNIT;
         cost_q = UNIT;
         count_cfg = 1;
         index_cfg = 0;
         present_cfg = 1'b1;
         wipe_node_state();
         duty_expected.delete();
         err_count = 0;
         seen_count = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_node_slot, rsp_duty, rsp_is_own, rsp_forced_full, rsp_last};
            seen_count++;
            if (duty_expected.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected duty result: slot %0d duty %h", got.slot, got.duty);
            end else begin
               want = duty_expected.pop_front();
               if (got != want) begin
                  err_count++;
                  if (err_count <= 10) begin
                     $display("duty mismatch exp: slot %0d duty %h own %b forced %b last %b",
                              want.slot, want.duty, want.own, want.forced, want.last);
                     $display("              got: slot %0d duty %h own %b forced %b last %b",
                              got.slot, got.duty, got.own, got.forced, got.last);
                  end
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_RHO:     rho_q = pwdata[30:0];
               REG_COST:    cost_q = pwdata[30:0];
               REG_COUNT:   count_cfg = pwdata[3:0];
               REG_INDEX:   index_cfg = pwdata[2:0];
               REG_PRESENT: present_cfg = pwdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_opcode)
               OP_ELEM: net_duty[req_row_index*8 + req_col_index] = req_value;
               OP_GAIN: gain_q[req_col_index] = req_value / 100;
               OP_CLEAR: wipe_node_state();
               OP_ITER: begin
                  n = count_cfg;
                  if (n < 1) n = 1;
                  if (n > 8) n = 8;
                  here = present_cfg && index_cfg < n;
                  forced = here ? solve_duties(n, index_cfg, req_measured_lux,
                                               req_reference_lux) : 1'b0;
                  if (forced) fail_count++;
                  for (int k = 0; k < n; k++)
                     duty_expected.push_back('{3'(k), here ? own_duty[k][22:0] : 23'd0,
                                               k == index_cfg, forced, k == n - 1});
               end
            endcase
         end
      end
      errors <= err_count;
      pending <= duty_expected.size();
      results_seen <= seen_count;
      failsafe_seen <= fail_count;
   end

endmodule

// ===== sim/admm_consensus_lighting_step_tb.sv =====
// Testbench top for the consensus lighting step: stimulus, register phases and verdict.
module admm_consensus_lighting_step_tb import acls_pkg::*;;

   localparam int CYCLE_LIMIT = 8000000;
   localparam int UNIT = 65536;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_opcode = OP_ELEM;
   logic [2:0]        req_row_index = '0;
   logic [2:0]        req_col_index = '0;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_measured_lux = '0;
   logic signed [31:0] req_reference_lux = '0;
   logic              rsp_valid;
   logic [2:0]        rsp_node_slot;
   logic [22:0]       rsp_duty;
   logic              rsp_is_own;
   logic              rsp_forced_full;
   logic              rsp_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [PAW-1:0]    paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   int errors, pending, results_seen, failsafe_seen;
   int cycle_count = 0;
   int idle_pct = 0;
   int items_sent = 0;
   int iterates_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   admm_consensus_lighting_step dut (.*);

   admm_consensus_lighting_step_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Hold the command until the block takes it; start stays high for a back-to-back transfer.
   task automatic issue(input logic [1:0] op, input logic [2:0] row, input logic [2:0] col,
                        input logic [31:0] val, input logic [31:0] meas, input logic [31:0] lux);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_value <= val;
      req_measured_lux <= meas;
      req_reference_lux <= lux;
      do @(posedge clock); while (busy);
      items_sent++;
      if (op == OP_ITER) iterates_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_duty();
      if ($urandom_range(99) < 80) return $urandom_range(0, 100 * UNIT);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_gain();
      if ($urandom_range(99) < 85) return $urandom_range(0, 200) * UNIT + $urandom_range(0, 65535);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_lux();
      if ($urandom_range(99) < 80) return $urandom_range(0, 400 * UNIT);
      return $urandom;
   endfunction

   task automatic random_item();
      int roll;
      roll = $urandom_range(99);
      if (roll < 38)
         issue(OP_ELEM, 3'($urandom), 3'($urandom), pick_duty(), $urandom, $urandom);
      else if (roll < 63)
         issue(OP_GAIN, 3'($urandom), 3'($urandom), pick_gain(), $urandom, $urandom);
      else if (roll < 97)
         issue(OP_ITER, 3'($urandom), 3'($urandom), $urandom, pick_lux(), pick_lux());
      else
         issue(OP_CLEAR, 3'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
   endtask

   logic [31:0] settings [8][5] = '{
      '{32'd65536, 32'd65536, 32'd4, 32'd1, 32'd1},
      '{32'd1, 32'd0, 32'd8, 32'd7, 32'd1},
      '{32'h7fffffff, 32'h7fffffff, 32'd3, 32'd2, 32'd1},
      '{32'd0, 32'd98304, 32'd0, 32'd0, 32'd1},
      '{32'd32768, 32'd65536, 32'd15, 32'd5, 32'd1},
      '{32'd65536, 32'd65536, 32'd5, 32'd6, 32'd1},
      '{32'd131072, 32'd40000, 32'd6, 32'd2, 32'd0},
      '{32'd262144, 32'd65536, 32'd8, 32'd3, 32'd1}
   };
   int phase_idle [4] = '{0, 60, 11, 0};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Edge values of every field under the reset settings.
      issue(OP_ELEM, 3'd0, 3'd0, 32'h7fffffff, 32'h0, 32'h0);
      issue(OP_ELEM, 3'd7, 3'd7, 32'h80000000, 32'hffffffff, 32'h80000000);
      issue(OP_GAIN, 3'd7, 3'd0, 32'h7fffffff, 32'h0, 32'h0);
      issue(OP_GAIN, 3'd0, 3'd7, 32'h80000000, 32'h0, 32'h0);
      issue(OP_ITER, 3'd0, 3'd0, 32'h0, 32'h7fffffff, 32'h80000000);
      issue(OP_ITER, 3'd7, 3'd7, 32'hffffffff, 32'h80000000, 32'h7fffffff);
      issue(OP_CLEAR, 3'd7, 3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      issue(OP_GAIN, 3'd0, 3'd0, 32'd150 * UNIT, 32'h0, 32'h0);
      issue(OP_ITER, 3'd0, 3'd0, 32'h0, 32'd10 * UNIT, 32'd200 * UNIT);
      issue(OP_ITER, 3'd0, 3'd0, 32'h0, 32'hffffffff, 32'h0);
      issue(OP_ITER, 3'd0, 3'd0, 32'h0, 32'd0, 32'h7fffffff);

      for (int p = 0; p < 8; p++) begin
         settle();
         for (int r = 0; r < 5; r++) write_reg(3'(r), settings[p][r]);
         idle_pct = phase_idle[p % 4];
         // Load a full gain row and some network duties before iterating.
         for (int g = 0; g < 8; g++)
            issue(OP_GAIN, 3'($urandom), 3'(g), $urandom_range(20, 200) * UNIT, 0, 0);
         for (int e = 0; e < 4; e++)
            issue(OP_ELEM, 3'($urandom), 3'($urandom), $urandom_range(0, 100 * UNIT), 0, 0);
         for (int k = 0; k < 20; k++) begin
            if (k == 10 && p == 2) settle();
            random_item();
         end
      end

      settle();
      $display("covered %0d commands, %0d iterates, 8 register settings; %0d duty results,",
               items_sent, iterates_sent, results_seen);
      $display("  %0d of the solves hit the full-duty failsafe", failsafe_seen);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
